### hw/rtl/ptm_pkg.sv
// ----------------------------------------------------------------------------
// ptm_pkg
// Shared constants, angle table and types for the polar tunnel map unit.
// ----------------------------------------------------------------------------
package ptm_pkg;

  localparam int COORD_BITS_DEF   = 10;
  localparam int CORDIC_STEPS_DEF = 16;

  // arctangent table depth; steps beyond it are not run
  localparam int TAB_LEN  = 24;
  // CORDIC vector width and scale target bit
  localparam int VEC_BITS = 64;
  localparam int VEC_TOP  = 60;
  // angle in turn units, 2^32 per turn
  localparam int ANG_BITS = 32;
  // accumulated angle: table sum stays well inside +/- 2^33
  localparam int Z_BITS   = 34;

  localparam logic [ANG_BITS-1:0] EIGHTH_TURN  = 32'h2000_0000;
  localparam logic [ANG_BITS-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [ANG_BITS-1:0] HALF_TURN    = 32'h8000_0000;

  // atan(2^-i) in turn units, rounded
  localparam logic [ANG_BITS-1:0] ATAN_TABLE [0:TAB_LEN-1] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
  };

  // how the first-octant angle is obtained
  typedef enum logic [1:0] {
    ANG_ZERO   = 2'd0,
    ANG_EIGHTH = 2'd1,
    ANG_CORDIC = 2'd2
  } ang_class_t;

endpackage

### hw/rtl/ptm_in_if.sv
// ----------------------------------------------------------------------------
// ptm_in_if
// Pixel offset channel: valid/ready handshake carrying one coordinate pair.
// ----------------------------------------------------------------------------
interface ptm_in_if #(
  parameter int COORD_BITS = 10
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] px;
  logic signed [COORD_BITS-1:0] py;

  modport source (output valid, output px, output py, input ready);
  modport sink   (input valid, input px, input py, output ready);
endinterface

### hw/rtl/ptm_out_if.sv
// ----------------------------------------------------------------------------
// ptm_out_if
// Texture coordinate channel: valid/ready handshake carrying angle and radius.
// ----------------------------------------------------------------------------
interface ptm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] angle_coord;
  logic [7:0] radius_coord;

  modport source (output valid, output angle_coord, output radius_coord, input ready);
  modport sink   (input valid, input angle_coord, input radius_coord, output ready);
endinterface

### hw/rtl/polar_tunnel_map_unit.sv
// ----------------------------------------------------------------------------
// polar_tunnel_map_unit
// Maps a signed pixel offset to tunnel texture coordinates (angle, radius).
// ----------------------------------------------------------------------------
// Takes one pixel item per clock and returns one result item per input, in
// order. The pipeline is three setup stages (input, abs/swap/square,
// sum/classify), one stage per iteration where a stage runs a CORDIC
// vectoring step, a bit of the restoring square root, or both side by side,
// then two stages that unfold the octant angle and one output register. The
// whole pipeline holds when the output register is full and not taken.
module polar_tunnel_map_unit #(
  parameter int COORD_BITS   = ptm_pkg::COORD_BITS_DEF,
  parameter int CORDIC_STEPS = ptm_pkg::CORDIC_STEPS_DEF
) (
  input logic       clk,
  input logic       rst,
  ptm_in_if.sink    pix,
  ptm_out_if.source tex
);
  import ptm_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int SQW   = 2 * CB;
  localparam int SCALE = VEC_TOP - CB;
  localparam int CS    = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;
  localparam int NIT   = (CS > CB) ? CS : CB;

  typedef struct packed {
    logic signed [VEC_BITS-1:0] cx;
    logic signed [VEC_BITS-1:0] cy;
    logic signed [Z_BITS-1:0]   z;
    logic [SQW-1:0]             rem;
    logic [SQW-1:0]             res;
    ang_class_t                 cls;
    logic                       swp;
    logic                       xneg;
    logic                       yneg;
  } it_t;

  logic adv;

  // input stage
  logic                 v0;
  logic signed [CB-1:0] x0, y0;

  // abs, swap, squares
  logic           v1;
  logic [CB-1:0]  ax1, ay1;
  logic [SQW-1:0] xsq1, ysq1;
  logic           swp1, xneg1, yneg1;

  // iteration chain; entry 0 is loaded by the setup stage
  logic it_v [0:NIT];
  it_t  it_q [0:NIT];

  // unfold stages
  logic                v4;
  logic [ANG_BITS-1:0] a4;
  logic                swp4, xneg4, yneg4;
  logic [7:0]          rad4;
  logic                v5;
  logic [ANG_BITS-1:0] a5;
  logic                yneg5;
  logic [7:0]          rad5;
  logic                v6;

  assign adv       = !v6 || tex.ready;
  assign pix.ready = adv;
  assign tex.valid = v6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= pix.valid;
    end
    if (adv) begin
      x0 <= pix.px;
      y0 <= pix.py;
    end
  end

  logic [CB-1:0]  abx, aby;
  logic [SQW-1:0] xsq, ysq;

  always_comb begin
    abx = x0[CB-1] ? (~x0 + CB'(1)) : x0;
    aby = y0[CB-1] ? (~y0 + CB'(1)) : y0;
    xsq = SQW'(x0) * SQW'(x0);
    ysq = SQW'(y0) * SQW'(y0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= v0;
    end
    if (adv) begin
      swp1  <= aby > abx;
      ax1   <= (aby > abx) ? aby : abx;
      ay1   <= (aby > abx) ? abx : aby;
      xsq1  <= xsq;
      ysq1  <= ysq;
      xneg1 <= x0[CB-1];
      yneg1 <= y0[CB-1];
    end
  end

  it_t setup;

  always_comb begin
    setup      = '0;
    setup.cx   = $signed(VEC_BITS'(ax1) << SCALE);
    setup.cy   = $signed(VEC_BITS'(ay1) << SCALE);
    setup.z    = '0;
    setup.rem  = xsq1 + ysq1;
    setup.res  = '0;
    setup.swp  = swp1;
    setup.xneg = xneg1;
    setup.yneg = yneg1;
    if (ay1 == '0) begin
      setup.cls = ANG_ZERO;
    end else if (ay1 == ax1) begin
      setup.cls = ANG_EIGHTH;
    end else begin
      setup.cls = ANG_CORDIC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      it_v[0] <= 1'b0;
    end else if (adv) begin
      it_v[0] <= v1;
    end
    if (adv) begin
      it_q[0] <= setup;
    end
  end

  for (genvar k = 0; k < NIT; k++) begin : g_iter
    it_t                        nxt;
    logic signed [VEC_BITS-1:0] cx_n, cy_n;
    logic signed [Z_BITS-1:0]   z_n;
    logic [SQW-1:0]             rem_n, res_n;

    if (k < CS) begin : g_cordic
      always_comb begin
        // one vectoring step: rotate toward the x axis
        if (it_q[k].cy > 0) begin
          cx_n = it_q[k].cx + (it_q[k].cy >>> k);
          cy_n = it_q[k].cy - (it_q[k].cx >>> k);
          z_n  = it_q[k].z + $signed({2'b00, ATAN_TABLE[k]});
        end else begin
          cx_n = it_q[k].cx - (it_q[k].cy >>> k);
          cy_n = it_q[k].cy + (it_q[k].cx >>> k);
          z_n  = it_q[k].z - $signed({2'b00, ATAN_TABLE[k]});
        end
      end
    end else begin : g_cordic_hold
      assign cx_n = it_q[k].cx;
      assign cy_n = it_q[k].cy;
      assign z_n  = it_q[k].z;
    end

    if (k < CB) begin : g_sqrt
      localparam logic [SQW-1:0] SQ_BIT = SQW'(1) << (2 * (CB - 1 - k));
      logic [SQW:0] trial;

      always_comb begin
        trial = {1'b0, it_q[k].res} + {1'b0, SQ_BIT};
        if ({1'b0, it_q[k].rem} >= trial) begin
          rem_n = it_q[k].rem - trial[SQW-1:0];
          res_n = (it_q[k].res >> 1) + SQ_BIT;
        end else begin
          rem_n = it_q[k].rem;
          res_n = it_q[k].res >> 1;
        end
      end
    end else begin : g_sqrt_hold
      assign rem_n = it_q[k].rem;
      assign res_n = it_q[k].res;
    end

    always_comb begin
      nxt     = it_q[k];
      nxt.cx  = cx_n;
      nxt.cy  = cy_n;
      nxt.z   = z_n;
      nxt.rem = rem_n;
      nxt.res = res_n;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        it_v[k+1] <= 1'b0;
      end else if (adv) begin
        it_v[k+1] <= it_v[k];
      end
      if (adv) begin
        it_q[k+1] <= nxt;
      end
    end
  end

  // clamp the octant angle and pick the fixed cases
  logic [ANG_BITS-1:0] zc, a_sel;
  logic [7:0]          rad_sel;

  always_comb begin
    if (it_q[NIT].z < 0) begin
      zc = '0;
    end else if (it_q[NIT].z > $signed({2'b00, EIGHTH_TURN})) begin
      zc = EIGHTH_TURN;
    end else begin
      zc = it_q[NIT].z[ANG_BITS-1:0];
    end
    unique case (it_q[NIT].cls)
      ANG_ZERO:   a_sel = '0;
      ANG_EIGHTH: a_sel = EIGHTH_TURN;
      ANG_CORDIC: a_sel = zc;
      default:    a_sel = '0;
    endcase
    rad_sel = (it_q[NIT].res == '0) ? 8'd1 : it_q[NIT].res[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= it_v[NIT];
    end
    if (adv) begin
      a4    <= a_sel;
      swp4  <= it_q[NIT].swp;
      xneg4 <= it_q[NIT].xneg;
      yneg4 <= it_q[NIT].yneg;
      rad4  <= rad_sel;
    end
  end

  // swap and x mirror folded into one add
  logic [ANG_BITS-1:0] a_unf;

  always_comb begin
    case ({swp4, xneg4})
      2'b00:   a_unf = a4;
      2'b10:   a_unf = QUARTER_TURN - a4;
      2'b01:   a_unf = HALF_TURN - a4;
      default: a_unf = QUARTER_TURN + a4;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
    if (adv) begin
      a5    <= a_unf;
      yneg5 <= yneg4;
      rad5  <= rad4;
    end
  end

  // y mirror plus the half-turn offset
  logic [ANG_BITS-1:0] theta;

  assign theta = yneg5 ? (HALF_TURN - a5) : (HALF_TURN + a5);

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= v5;
    end
    if (adv) begin
      tex.angle_coord  <= theta[ANG_BITS-1 -: 8];
      tex.radius_coord <= rad5;
    end
  end

endmodule
